>>> sv/hss_pkg.sv
package hss_pkg;

    // Fixed field widths
    localparam int TEMP_BITS = 12;
    localparam int HYST_BITS = 9;
    localparam int MODE_BITS = 3;
    localparam int RELAY_BITS = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = (TEMP_BITS > HYST_BITS) ? TEMP_BITS : HYST_BITS;

    // Relay codes
    localparam logic [RELAY_BITS-1:0] RELAY_OFF  = 2'd0;
    localparam logic [RELAY_BITS-1:0] RELAY_GRID = 2'd1;
    localparam logic [RELAY_BITS-1:0] RELAY_SUN  = 2'd2;

    // Heater modes (codes above MODE_ALLOFF run as auto)
    localparam logic [MODE_BITS-1:0] MODE_AUTO   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_BOOST  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_AWAY   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_NOGRID = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_ALLOFF = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SETPOINT     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_LIMIT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LIMIT    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HYSTERESIS   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOOST_TARGET = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AWAY_TARGET  = 3'd5;

    // Register reset values
    localparam logic [TEMP_BITS-1:0] SETPOINT_RST     = TEMP_BITS'(550);
    localparam logic [TEMP_BITS-1:0] MIN_LIMIT_RST    = TEMP_BITS'(50);
    localparam logic [TEMP_BITS-1:0] MAX_LIMIT_RST    = TEMP_BITS'(850);
    localparam logic [HYST_BITS-1:0] HYSTERESIS_RST   = HYST_BITS'(20);
    localparam logic [TEMP_BITS-1:0] BOOST_TARGET_RST = TEMP_BITS'(700);
    localparam logic [TEMP_BITS-1:0] AWAY_TARGET_RST  = TEMP_BITS'(100);

    typedef struct packed {
        logic [MODE_BITS-1:0]        mode;
        logic signed [TEMP_BITS-1:0] boiler_temp;
        logic                        temp_fault;
        logic                        power_fault;
        logic                        test_unselected;
    } in_item_t;

    typedef struct packed {
        logic [RELAY_BITS-1:0] relay_choice;
        logic                  relay_changed;
        logic                  boost_done;
        logic                  over_max_latched;
    } out_item_t;

endpackage

>>> sv/heater_source_selector_top.sv
// Heater source selector: each request (mode, boiler temperature, fault flags) yields one
// result with the relay source (off, grid or sun), a changed flag, boost done and the
// over-maximum latch. A request is taken into an input register, decided by compare and
// select logic against the configuration and the relay/latch state, and lands in a result
// register; one request per cycle is sustained while out_ready takes every result.
// The result register lets a new request enter while a finished result still waits.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user must write it only while
// idle, which the block itself does not enforce. Unknown indexes are ignored.
module heater_source_selector_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [hss_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [hss_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  hss_pkg::in_item_t                     in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output hss_pkg::out_item_t                    out_data
);

    localparam int TB = hss_pkg::TEMP_BITS;
    localparam int W  = TB + 2;

    // Configuration registers
    logic [TB-1:0]                 setpoint_reg;
    logic [TB-1:0]                 min_limit_reg;
    logic [TB-1:0]                 max_limit_reg;
    logic [hss_pkg::HYST_BITS-1:0] hysteresis_reg;
    logic [TB-1:0]                 boost_target_reg;
    logic [TB-1:0]                 away_target_reg;

    // Decision state
    logic [hss_pkg::RELAY_BITS-1:0] relay_now_reg;
    logic                           max_reached_reg;
    logic                           first_decision_reg;

    // Pipeline registers
    logic               in_valid_reg;
    hss_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    hss_pkg::out_item_t out_item_reg;

    logic advance;

    // Decision signals
    logic signed [W-1:0] t_x, sp_x, tmin_x, tmax_x, bt_x, at_x, h_x;
    logic [hss_pkg::RELAY_BITS-1:0] choice;
    logic [hss_pkg::RELAY_BITS-1:0] choice_next;
    logic                           done;
    logic                           max_reached_next;
    logic                           latch_hold;
    logic                           first_decision_next;
    logic                           below_sp;
    hss_pkg::out_item_t             out_item_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg     <= hss_pkg::SETPOINT_RST;
            min_limit_reg    <= hss_pkg::MIN_LIMIT_RST;
            max_limit_reg    <= hss_pkg::MAX_LIMIT_RST;
            hysteresis_reg   <= hss_pkg::HYSTERESIS_RST;
            boost_target_reg <= hss_pkg::BOOST_TARGET_RST;
            away_target_reg  <= hss_pkg::AWAY_TARGET_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hss_pkg::REG_SETPOINT:     setpoint_reg     <= cfg_data[TB-1:0];
                hss_pkg::REG_MIN_LIMIT:    min_limit_reg    <= cfg_data[TB-1:0];
                hss_pkg::REG_MAX_LIMIT:    max_limit_reg    <= cfg_data[TB-1:0];
                hss_pkg::REG_HYSTERESIS:   hysteresis_reg   <= cfg_data[hss_pkg::HYST_BITS-1:0];
                hss_pkg::REG_BOOST_TARGET: boost_target_reg <= cfg_data[TB-1:0];
                hss_pkg::REG_AWAY_TARGET:  away_target_reg  <= cfg_data[TB-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: input register drains into result register when that slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Sign-extend operands so sums and differences never wrap
    always_comb
    begin
        t_x    = {{2{in_item_reg.boiler_temp[TB-1]}}, in_item_reg.boiler_temp};
        sp_x   = {{2{setpoint_reg[TB-1]}}, setpoint_reg};
        tmin_x = {{2{min_limit_reg[TB-1]}}, min_limit_reg};
        tmax_x = {{2{max_limit_reg[TB-1]}}, max_limit_reg};
        bt_x   = {{2{boost_target_reg[TB-1]}}, boost_target_reg};
        at_x   = {{2{away_target_reg[TB-1]}}, away_target_reg};
        h_x    = {{(W - hss_pkg::HYST_BITS){1'b0}}, hysteresis_reg};
    end

    // Decide the relay source
    always_comb
    begin
        choice              = relay_now_reg;
        done                = 1'b0;
        first_decision_next = first_decision_reg;
        below_sp            = (t_x < sp_x);

        // Release the over-maximum latch below max minus hysteresis
        latch_hold = max_reached_reg && !((t_x + h_x) < tmax_x);

        if (latch_hold)
        begin
            choice = hss_pkg::RELAY_OFF;
        end
        else
        begin
            case (in_item_reg.mode)
                hss_pkg::MODE_BOOST:
                begin
                    if (t_x > bt_x)
                        done = 1'b1;
                    else
                        choice = hss_pkg::RELAY_GRID;
                end
                hss_pkg::MODE_AWAY:
                begin
                    if (relay_now_reg == hss_pkg::RELAY_GRID)
                        choice = (t_x < at_x + h_x) ? hss_pkg::RELAY_GRID : hss_pkg::RELAY_SUN;
                    else if (relay_now_reg == hss_pkg::RELAY_SUN)
                        choice = (t_x > at_x - h_x) ? hss_pkg::RELAY_SUN : hss_pkg::RELAY_GRID;
                    else
                        choice = hss_pkg::RELAY_SUN;
                end
                hss_pkg::MODE_NOGRID: choice = hss_pkg::RELAY_SUN;
                hss_pkg::MODE_ALLOFF: choice = hss_pkg::RELAY_OFF;
                default:
                begin
                    // Auto: plain compare on the first decision or with relay off
                    first_decision_next = 1'b0;
                    if (!first_decision_reg && relay_now_reg == hss_pkg::RELAY_GRID)
                        choice = (t_x < sp_x + h_x) ? hss_pkg::RELAY_GRID : hss_pkg::RELAY_SUN;
                    else if (!first_decision_reg && relay_now_reg == hss_pkg::RELAY_SUN)
                        choice = (t_x > sp_x - h_x) ? hss_pkg::RELAY_SUN : hss_pkg::RELAY_GRID;
                    else
                        choice = below_sp ? hss_pkg::RELAY_GRID : hss_pkg::RELAY_SUN;
                end
            endcase
        end

        // Apply overrides in order
        choice_next      = choice;
        max_reached_next = latch_hold;
        if (in_item_reg.temp_fault)
            choice_next = hss_pkg::RELAY_OFF;
        if (choice_next == hss_pkg::RELAY_SUN && in_item_reg.power_fault)
            choice_next = hss_pkg::RELAY_OFF;
        if (t_x < tmin_x || t_x > tmax_x)
        begin
            if (t_x > tmax_x)
                max_reached_next = 1'b1;
            choice_next = hss_pkg::RELAY_OFF;
        end
        if (in_item_reg.test_unselected)
            choice_next = hss_pkg::RELAY_OFF;

        out_item_next.relay_choice     = choice_next;
        out_item_next.relay_changed    = (choice_next != relay_now_reg);
        out_item_next.boost_done       = done;
        out_item_next.over_max_latched = max_reached_next;
    end

    // Hold control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            relay_now_reg      <= hss_pkg::RELAY_OFF;
            max_reached_reg    <= 1'b0;
            first_decision_reg <= 1'b1;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                relay_now_reg      <= choice_next;
                max_reached_reg    <= max_reached_next;
                first_decision_reg <= first_decision_next;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= out_item_next;
    end

`ifndef SYNTHESIS
    a_latch_forces_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.over_max_latched
            |-> out_item_reg.relay_choice == hss_pkg::RELAY_OFF)
        else $error("over-maximum latch set with relay not off");

    a_relay_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> relay_now_reg == out_item_reg.relay_choice)
        else $error("relay state differs from delivered choice");

    a_latch_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> max_reached_reg == out_item_reg.over_max_latched)
        else $error("latch state differs from delivered flag");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_valid_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.relay_choice != 2'd3)
        else $error("illegal relay code");
`endif

endmodule

>>> bench/heater_source_selector_top_test.sv
`timescale 1ns / 100ps

module heater_source_selector_top_test;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_ITEMS     = 60;
    localparam int PHASE_COUNT     = 7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DIRECTED_ROWS   = 26;

    // Register indexes the block does not decode
    localparam logic [hss_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [hss_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

    // One directed request, with its typed result where pinned is set
    typedef struct packed {
        logic [hss_pkg::MODE_BITS-1:0]        mode;
        logic signed [hss_pkg::TEMP_BITS-1:0] temp;
        logic                                 temp_fault;
        logic                                 power_fault;
        logic                                 test_unselected;
        logic                                 pinned;
        logic [hss_pkg::RELAY_BITS-1:0]       relay;
        logic                                 changed;
        logic                                 done;
        logic                                 latched;
    } plan_row_t;

    typedef struct {
        int setpoint;
        int min_limit;
        int max_limit;
        int hysteresis;
        int boost_target;
        int away_target;
    } heat_setting_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_wr_en;
    logic [hss_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [hss_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    hss_pkg::in_item_t                  in_data;
    logic                               out_valid;
    logic                               out_ready;
    hss_pkg::out_item_t                 out_data;

    // Shadow configuration
    logic [hss_pkg::TEMP_BITS-1:0] sp_reg;
    logic [hss_pkg::TEMP_BITS-1:0] min_reg;
    logic [hss_pkg::TEMP_BITS-1:0] max_reg;
    logic [hss_pkg::HYST_BITS-1:0] hyst_reg;
    logic [hss_pkg::TEMP_BITS-1:0] boost_reg;
    logic [hss_pkg::TEMP_BITS-1:0] away_reg;

    // Shadow selector state
    logic [hss_pkg::RELAY_BITS-1:0] relay_state;
    logic                           over_max;
    logic                           first_auto;

    hss_pkg::out_item_t expected_results[$];
    logic               pin_expect;
    hss_pkg::out_item_t pinned_result;
    logic               hold_off_req;
    int                 burst_left;
    int                 fail_count;
    int                 cycle_count;

    plan_row_t directed_rows[DIRECTED_ROWS] = '{
        '{hss_pkg::MODE_AUTO,   12'd300,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_GRID, 1'b1, 1'b0, 1'b0},
        '{hss_pkg::MODE_AUTO,   12'd560,  1'b0, 1'b0, 1'b0, 1'b0,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_AUTO,   12'd575,  1'b0, 1'b0, 1'b0, 1'b0,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_AUTO,   12'd531,  1'b0, 1'b0, 1'b0, 1'b0,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_AUTO,   12'd530,  1'b0, 1'b0, 1'b0, 1'b0,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_BOOST,  12'd600,  1'b0, 1'b0, 1'b0, 1'b0,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_BOOST,  12'd701,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_GRID, 1'b0, 1'b1, 1'b0},
        '{hss_pkg::MODE_AWAY,   12'd200,  1'b0, 1'b0, 1'b0, 1'b0,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_AWAY,   12'd81,   1'b0, 1'b0, 1'b0, 1'b0,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_AWAY,   12'd80,   1'b0, 1'b0, 1'b0, 1'b0,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_NOGRID, 12'd400,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_SUN,  1'b1, 1'b0, 1'b0},
        '{hss_pkg::MODE_NOGRID, 12'd400,  1'b0, 1'b1, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b1, 1'b0, 1'b0},
        '{hss_pkg::MODE_AWAY,   12'd400,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_SUN,  1'b1, 1'b0, 1'b0},
        '{hss_pkg::MODE_ALLOFF, 12'd400,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b1, 1'b0, 1'b0},
        '{hss_pkg::MODE_AUTO,   12'd600,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_SUN,  1'b1, 1'b0, 1'b0},
        '{hss_pkg::MODE_AUTO,   12'd600,  1'b1, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b1, 1'b0, 1'b0},
        '{hss_pkg::MODE_AUTO,   12'd600,  1'b0, 1'b0, 1'b1, 1'b1,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_AUTO,   12'd40,   1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{hss_pkg::MODE_BOOST,  12'd851,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b0, 1'b1, 1'b1},
        '{hss_pkg::MODE_AUTO,   12'd840,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b1},
        '{hss_pkg::MODE_BOOST,  12'd835,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b1},
        '{hss_pkg::MODE_AUTO,   12'd829,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_SUN,  1'b1, 1'b0, 1'b0},
        '{3'd7,                 12'h7FF,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b1, 1'b0, 1'b1},
        '{3'd5,                 12'h800,  1'b0, 1'b0, 1'b0, 1'b1,
          hss_pkg::RELAY_OFF,  1'b0, 1'b0, 1'b0},
        '{3'd6,                 12'd300,  1'b0, 1'b1, 1'b0, 1'b1,
          hss_pkg::RELAY_GRID, 1'b1, 1'b0, 1'b0},
        '{hss_pkg::MODE_BOOST,  12'd700,  1'b1, 1'b1, 1'b1, 1'b1,
          hss_pkg::RELAY_OFF,  1'b1, 1'b0, 1'b0}
    };

    heater_source_selector_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Hysteresis pick shared by auto and away modes
    function automatic logic [hss_pkg::RELAY_BITS-1:0] band_pick(int t, int target, int h,
        logic [hss_pkg::RELAY_BITS-1:0] when_off);
        if (relay_state == hss_pkg::RELAY_GRID)
            return (t < target + h) ? hss_pkg::RELAY_GRID : hss_pkg::RELAY_SUN;
        if (relay_state == hss_pkg::RELAY_SUN)
            return (t > target - h) ? hss_pkg::RELAY_SUN : hss_pkg::RELAY_GRID;
        return when_off;
    endfunction

    // Advance the shadow selector by one request and return its result
    function automatic hss_pkg::out_item_t predict_relay(hss_pkg::in_item_t req);
        int                             t;
        int                             h;
        int                             sp;
        int                             tmin;
        int                             tmax;
        int                             bt;
        int                             at;
        logic [hss_pkg::RELAY_BITS-1:0] choice;
        logic [hss_pkg::RELAY_BITS-1:0] prior;
        logic [hss_pkg::RELAY_BITS-1:0] plain;
        logic                           done;
        hss_pkg::out_item_t             res;
        t      = $signed(req.boiler_temp);
        h      = int'(hyst_reg);
        sp     = $signed(sp_reg);
        tmin   = $signed(min_reg);
        tmax   = $signed(max_reg);
        bt     = $signed(boost_reg);
        at     = $signed(away_reg);
        prior  = relay_state;
        choice = relay_state;
        done   = 1'b0;

        // Release the over-maximum latch once well below the limit
        if (over_max && (t + h < tmax))
            over_max = 1'b0;

        if (over_max)
        begin
            choice = hss_pkg::RELAY_OFF;
        end
        else
        begin
            case (req.mode)
                hss_pkg::MODE_BOOST:
                begin
                    if (t > bt)
                        done = 1'b1;
                    else
                        choice = hss_pkg::RELAY_GRID;
                end
                hss_pkg::MODE_AWAY:   choice = band_pick(t, at, h, hss_pkg::RELAY_SUN);
                hss_pkg::MODE_NOGRID: choice = hss_pkg::RELAY_SUN;
                hss_pkg::MODE_ALLOFF: choice = hss_pkg::RELAY_OFF;
                default:
                begin
                    plain = (t < sp) ? hss_pkg::RELAY_GRID : hss_pkg::RELAY_SUN;
                    if (first_auto)
                    begin
                        first_auto = 1'b0;
                        choice     = plain;
                    end
                    else
                    begin
                        choice = band_pick(t, sp, h, plain);
                    end
                end
            endcase
        end

        // Apply overrides in priority order
        if (req.temp_fault)
            choice = hss_pkg::RELAY_OFF;
        if (choice == hss_pkg::RELAY_SUN && req.power_fault)
            choice = hss_pkg::RELAY_OFF;
        if (t < tmin || t > tmax)
        begin
            if (t > tmax)
                over_max = 1'b1;
            choice = hss_pkg::RELAY_OFF;
        end
        if (req.test_unselected)
            choice = hss_pkg::RELAY_OFF;

        relay_state          = choice;
        res.relay_choice     = choice;
        res.relay_changed    = (choice != prior);
        res.boost_done       = done;
        res.over_max_latched = over_max;
        return res;
    endfunction

    // Check results and predict each accepted request
    always @(posedge clk)
    begin : scoreboard
        hss_pkg::out_item_t want;
        hss_pkg::out_item_t model;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.relay_choice !== want.relay_choice)
                    begin
                        $error("relay_choice: expected %0d, got %0d",
                               want.relay_choice, out_data.relay_choice);
                        fail_count++;
                    end
                    if (out_data.relay_changed !== want.relay_changed)
                    begin
                        $error("relay_changed: expected %0d, got %0d",
                               want.relay_changed, out_data.relay_changed);
                        fail_count++;
                    end
                    if (out_data.boost_done !== want.boost_done)
                    begin
                        $error("boost_done: expected %0d, got %0d",
                               want.boost_done, out_data.boost_done);
                        fail_count++;
                    end
                    if (out_data.over_max_latched !== want.over_max_latched)
                    begin
                        $error("over_max_latched: expected %0d, got %0d",
                               want.over_max_latched, out_data.over_max_latched);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                model = predict_relay(in_data);
                expected_results.push_back(pin_expect ? pinned_result : model);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("heater_source_selector_top regression: fail");
            $finish;
        end
    end

    // Drive out_ready from rotating patterns, with one long hold-off on request
    initial
    begin : ready_driver
        logic [7:0] ready_pattern;
        int         pattern_left;
        int         pattern_pos;
        int         hold_left;
        ready_pattern = 8'hFF;
        pattern_left  = 0;
        pattern_pos   = 0;
        hold_left     = 0;
        out_ready     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
                    if (ready_pattern == 8'h00)
                        ready_pattern = 8'h01;
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                pattern_pos = (pattern_pos + 1) % 8;
                out_ready <= ready_pattern[pattern_pos];
            end
        end
    end

    // Offer one request, idling between bursts, and hold it until accepted
    task automatic send_request(hss_pkg::in_item_t req, logic pinned,
                                hss_pkg::out_item_t pin_val);
        int gap_len;
        if (burst_left == 0)
        begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap_len)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 12);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        in_data       <= req;
        pin_expect    = pinned;
        pinned_result = pin_val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(logic [hss_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [hss_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            hss_pkg::REG_SETPOINT:     sp_reg    = data[hss_pkg::TEMP_BITS-1:0];
            hss_pkg::REG_MIN_LIMIT:    min_reg   = data[hss_pkg::TEMP_BITS-1:0];
            hss_pkg::REG_MAX_LIMIT:    max_reg   = data[hss_pkg::TEMP_BITS-1:0];
            hss_pkg::REG_HYSTERESIS:   hyst_reg  = data[hss_pkg::HYST_BITS-1:0];
            hss_pkg::REG_BOOST_TARGET: boost_reg = data[hss_pkg::TEMP_BITS-1:0];
            hss_pkg::REG_AWAY_TARGET:  away_reg  = data[hss_pkg::TEMP_BITS-1:0];
            default: ;
        endcase
    endtask

    // Load a full setting, plus writes to undecoded indexes
    task automatic apply_setting(heat_setting_t s);
        logic [hss_pkg::CFG_DATA_BITS-1:0] hyst_word;
        hyst_word = hss_pkg::CFG_DATA_BITS'(s.hysteresis)
                  | (hss_pkg::CFG_DATA_BITS'($urandom_range(0, 7)) << hss_pkg::HYST_BITS);
        write_reg(hss_pkg::REG_SETPOINT, hss_pkg::CFG_DATA_BITS'(s.setpoint));
        write_reg(hss_pkg::REG_MIN_LIMIT, hss_pkg::CFG_DATA_BITS'(s.min_limit));
        write_reg(hss_pkg::REG_MAX_LIMIT, hss_pkg::CFG_DATA_BITS'(s.max_limit));
        write_reg(hss_pkg::REG_HYSTERESIS, hyst_word);
        write_reg(hss_pkg::REG_BOOST_TARGET, hss_pkg::CFG_DATA_BITS'(s.boost_target));
        write_reg(hss_pkg::REG_AWAY_TARGET, hss_pkg::CFG_DATA_BITS'(s.away_target));
        write_reg(REG_SPARE_LO, hss_pkg::CFG_DATA_BITS'($urandom));
        write_reg(REG_SPARE_HI, hss_pkg::CFG_DATA_BITS'($urandom));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : main_sequence
        hss_pkg::in_item_t             req;
        hss_pkg::out_item_t            pin;
        heat_setting_t                 phase_settings[PHASE_COUNT];
        logic [hss_pkg::MODE_BITS-1:0] cur_mode;
        int                            mode_left;
        int                            cur_t;
        int                            step;
        int                            anchor;
        int                            p;
        int                            i;

        // Known levels on every input from time zero
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        pin_expect    = 1'b0;
        pinned_result = '0;
        hold_off_req  = 1'b0;
        burst_left    = 0;
        fail_count    = 0;
        cycle_count   = 0;
        sp_reg        = hss_pkg::SETPOINT_RST;
        min_reg       = hss_pkg::MIN_LIMIT_RST;
        max_reg       = hss_pkg::MAX_LIMIT_RST;
        hyst_reg      = hss_pkg::HYSTERESIS_RST;
        boost_reg     = hss_pkg::BOOST_TARGET_RST;
        away_reg      = hss_pkg::AWAY_TARGET_RST;
        relay_state   = hss_pkg::RELAY_OFF;
        over_max      = 1'b0;
        first_auto    = 1'b1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table at reset configuration
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            req.mode                 = directed_rows[i].mode;
            req.boiler_temp          = directed_rows[i].temp;
            req.temp_fault           = directed_rows[i].temp_fault;
            req.power_fault          = directed_rows[i].power_fault;
            req.test_unselected      = directed_rows[i].test_unselected;
            pin.relay_choice         = directed_rows[i].relay;
            pin.relay_changed        = directed_rows[i].changed;
            pin.boost_done           = directed_rows[i].done;
            pin.over_max_latched     = directed_rows[i].latched;
            send_request(req, directed_rows[i].pinned, pin);
        end
        wait_idle();

        // Settings per random phase: defaults, random, extremes, inverted limits
        phase_settings[0] = '{550, 50, 850, 20, 700, 100};
        phase_settings[1] = '{int'($urandom_range(0, 3000)) - 1000,
                              -1000 + int'($urandom_range(0, 600)),
                              int'($urandom_range(800, 2000)), int'($urandom_range(0, 500)),
                              int'($urandom_range(0, 3000)) - 1000,
                              int'($urandom_range(0, 3000)) - 1000};
        phase_settings[2] = '{-1000, -1000, 2000, 500, 2000, -1000};
        phase_settings[3] = '{2047, -2048, 2047, 0, -2048, 2047};
        phase_settings[4] = '{0, -200, 900, 1, 450, 300};
        phase_settings[5] = '{-2048, 300, 200, 511, 2047, -2048};
        phase_settings[6] = '{int'($urandom_range(0, 3000)) - 1000,
                              int'($urandom_range(0, 3000)) - 1000,
                              int'($urandom_range(0, 3000)) - 1000, int'($urandom_range(0, 511)),
                              int'($urandom_range(0, 3000)) - 1000,
                              int'($urandom_range(0, 3000)) - 1000};

        cur_mode  = hss_pkg::MODE_AUTO;
        mode_left = 0;
        cur_t     = 500;
        pin       = '0;
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            apply_setting(phase_settings[p]);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Hold a mode for a run of requests
                if (mode_left == 0)
                begin
                    cur_mode  = hss_pkg::MODE_BITS'($urandom_range(0, 7));
                    mode_left = $urandom_range(1, 20);
                end
                mode_left--;

                // Jump near a threshold now and then, else drift across the band
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 6))
                        0:       anchor = $signed(sp_reg);
                        1:       anchor = $signed(away_reg);
                        2:       anchor = $signed(boost_reg);
                        3:       anchor = $signed(min_reg);
                        4:       anchor = $signed(max_reg);
                        5:       anchor = int'($urandom_range(0, 4095)) - 2048;
                        default: anchor = int'($urandom_range(0, 3000)) - 1000;
                    endcase
                    cur_t = anchor + int'($urandom_range(0, 80)) - 40;
                end
                else
                begin
                    step  = int'(hyst_reg) / 2 + 4;
                    cur_t = cur_t + int'($urandom_range(0, 2 * step)) - step;
                end
                if (cur_t > 2047)
                    cur_t = 2047;
                if (cur_t < -2048)
                    cur_t = -2048;

                req.mode            = cur_mode;
                req.boiler_temp     = hss_pkg::TEMP_BITS'(cur_t);
                req.temp_fault      = ($urandom_range(0, 11) == 0);
                req.power_fault     = ($urandom_range(0, 11) == 0);
                req.test_unselected = ($urandom_range(0, 11) == 0);

                // Stall the receiver long enough to back up the input
                if (p == 3 && i == 20)
                    hold_off_req = 1'b1;
                send_request(req, 1'b0, pin);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("heater_source_selector_top regression: pass");
        else
            $display("heater_source_selector_top regression: fail");
        $finish;
    end

endmodule
